// File: rtl/bdac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdac_pkg: shared types and constants of the bayer diagonal average unit
// Widths, register indexes, channel codes and the item record that travels
// from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package bdac_pkg;

	// largest image row the line store holds
	localparam int MAX_WIDTH_DEF = 1024;

	// configuration register fields
	localparam int IMG_W_BITS   = 11;
	localparam int IMG_H_BITS   = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;

	// rows are tracked up to the height limit plus the extra grid row
	localparam int ROW_BITS     = 13;
	localparam int HEIGHT_LIMIT = 4096;

	// register reset values
	localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = IMG_W_BITS'(640);
	localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = IMG_H_BITS'(480);

	// pixel and result widths
	localparam int PIX_W      = 8;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 4;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// color channel codes
	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} channel_t;

	// one classified pixel waiting for its average
	typedef struct packed {
		logic [PIX_W-1:0] up_left;
		logic [PIX_W-1:0] up_right;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] here;
		logic             use_up_left;
		logic             use_up_right;
		logic             use_left;
		logic             use_here;
		channel_t         channel;
		logic             end_of_row;
		logic             end_of_frame;
	} bdac_item_t;

endpackage
`default_nettype wire

// File: rtl/bdac_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdac_ram: generic simple dual port ram
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module bdac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/bdac_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdac_front: grid tracking, classification and line store access
// Follows the grid position, picks the channel of each pixel, keeps the two
// row line store and the short history, and hands classified items on.
// ----------------------------------------------------------------------------
module bdac_front import bdac_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire logic [PIX_W-1:0]       in_red,
	input  wire logic [PIX_W-1:0]       in_green,
	input  wire logic [PIX_W-1:0]       in_blue,
	output      logic                   push,
	output      bdac_item_t             push_item,
	input  wire logic                   queue_full
);

	localparam int CW        = $clog2(MAX_WIDTH + 2);
	localparam int XW        = (CW > IMG_W_BITS) ? CW : IMG_W_BITS;
	localparam int SW        = CW + 1;
	localparam int RAM_DEPTH = 2 * MAX_WIDTH;
	localparam int AW        = $clog2(RAM_DEPTH);

	// configuration and position state
	logic [IMG_W_BITS-1:0] image_width_q;
	logic [IMG_H_BITS-1:0] image_height_q;
	logic [CW-1:0]         col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [PIX_W-1:0]      rec0_q;
	logic [PIX_W-1:0]      rec1_q;

	// clearing pass
	logic                  clr_busy_q;
	logic [AW-1:0]         clr_addr_q;

	// effective sizes and current position
	logic [CW-1:0]         w_eff;
	logic [CW-1:0]         w_p1;
	logic [ROW_BITS-1:0]   h_eff;
	logic [ROW_BITS-1:0]   h_p1;
	logic                  col_wrap;
	logic [ROW_BITS-1:0]   row_adj;
	logic [CW-1:0]         col_cur;
	logic [ROW_BITS-1:0]   row_cur;
	logic                  last_col;
	logic                  r_ge2;
	logic                  c_ge2;
	logic                  r_in;
	logic                  c_in;
	channel_t              sel;
	logic [PIX_W-1:0]      cur;
	logic [SW-1:0]         slot_base;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic                  accept;

	// line store port signals
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [PIX_W-1:0]      ram_wdata;
	logic                  ram_re;
	logic [PIX_W-1:0]      ram_rdata;

	// stage one registers
	logic                  valid_s1;
	logic                  emit_s1;
	logic                  use_up_left_s1;
	logic                  use_up_right_s1;
	logic                  use_left_s1;
	logic                  use_here_s1;
	channel_t              sel_s1;
	logic [PIX_W-1:0]      cur_s1;
	logic [PIX_W-1:0]      left_s1;
	logic                  eor_s1;
	logic                  eof_s1;
	logic                  move_s1;

	// values read two and one columns back
	logic [PIX_W-1:0]      rd_d1_q;
	logic [PIX_W-1:0]      rd_d2_q;

	// effective sizes from the registers
	always_comb begin
		if (XW'(image_width_q) > XW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(image_width_q);
		end
		if (image_height_q > IMG_H_BITS'(HEIGHT_LIMIT)) begin
			h_eff = ROW_BITS'(HEIGHT_LIMIT);
		end else begin
			h_eff = ROW_BITS'(image_height_q);
		end
		w_p1 = w_eff + CW'(1);
		h_p1 = h_eff + ROW_BITS'(1);
	end

	// position of this pixel, rewrapped against the present size
	always_comb begin
		col_wrap = (col_q > w_p1);
		row_adj  = col_wrap ? row_q + ROW_BITS'(1) : row_q;
		col_cur  = col_wrap ? '0 : col_q;
		row_cur  = (row_adj > h_p1) ? '0 : row_adj;
		last_col = (col_cur == w_p1);
		r_ge2    = (row_cur >= ROW_BITS'(2));
		c_ge2    = (col_cur >= CW'(2));
		r_in     = (row_cur < h_eff);
		c_in     = (col_cur < w_eff);
	end

	// channel fed by this position and its value
	always_comb begin
		if (row_cur[0] && col_cur[0]) begin
			sel = CH_RED;
		end else if (!row_cur[0] && !col_cur[0]) begin
			sel = CH_BLUE;
		end else begin
			sel = CH_GREEN;
		end
		case (sel)
			CH_RED:   cur = in_red;
			CH_GREEN: cur = in_green;
			CH_BLUE:  cur = in_blue;
			default:  cur = '0;
		endcase
		if (!(r_in && c_in)) begin
			cur = '0;
		end
	end

	// line store addresses: read this column, write two columns back
	always_comb begin
		slot_base = row_cur[0] ? SW'(MAX_WIDTH) : '0;
		rd_addr   = AW'(slot_base + SW'(col_cur));
		wr_addr   = AW'(slot_base + SW'(col_cur) - SW'(2));
	end

	// handshake
	always_comb begin
		move_s1  = valid_s1 && (!emit_s1 || !queue_full);
		in_ready = !clr_busy_q && (!valid_s1 || move_s1);
		accept   = in_valid && in_ready;
		push     = valid_s1 && emit_s1 && !queue_full;
	end

	// line store port muxing with the clearing pass
	always_comb begin
		ram_we    = clr_busy_q || (accept && c_ge2);
		ram_waddr = clr_busy_q ? clr_addr_q : wr_addr;
		ram_wdata = clr_busy_q ? '0 : rec1_q;
		ram_re    = accept && c_in;
	end

	bdac_ram #(
		.WIDTH (PIX_W),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clearing pass over the line store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(RAM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// grid position and recent values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rec0_q <= '0;
			rec1_q <= '0;
		end else if (accept) begin
			rec1_q <= rec0_q;
			rec0_q <= cur;
			if (last_col) begin
				col_q <= '0;
				row_q <= (row_cur == h_p1) ? '0 : row_cur + ROW_BITS'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1         <= (row_cur != '0) && (col_cur != '0);
			use_up_left_s1  <= r_ge2 && c_ge2;
			use_up_right_s1 <= r_ge2 && c_in;
			use_left_s1     <= r_in && c_ge2;
			use_here_s1     <= r_in && c_in;
			sel_s1          <= sel;
			cur_s1          <= cur;
			left_s1         <= rec1_q;
			eor_s1          <= last_col;
			eof_s1          <= last_col && (row_cur == h_p1);
		end
	end

	// read history: each item leaves its read value behind
	always_ff @(posedge clk) begin
		if (move_s1) begin
			rd_d1_q <= ram_rdata;
			rd_d2_q <= rd_d1_q;
		end
	end

	// item handed to the queue
	always_comb begin
		push_item.up_left      = rd_d2_q;
		push_item.up_right     = ram_rdata;
		push_item.left         = left_s1;
		push_item.here         = cur_s1;
		push_item.use_up_left  = use_up_left_s1;
		push_item.use_up_right = use_up_right_s1;
		push_item.use_left     = use_left_s1;
		push_item.use_here     = use_here_s1;
		push_item.channel      = sel_s1;
		push_item.end_of_row   = eor_s1;
		push_item.end_of_frame = eof_s1;
	end

endmodule
`default_nettype wire

// File: rtl/bdac_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdac_queue: short queue between front end and back end
// Register based first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module bdac_queue import bdac_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire bdac_item_t push_item,
	output      logic       full,
	input  wire logic       pop,
	output      bdac_item_t head,
	output      logic       empty
);

	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	bdac_item_t      entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	// status
	always_comb begin
		full  = (count_q == CNTW'(QUEUE_DEPTH));
		empty = (count_q == '0);
		head  = entry_q[rd_ptr_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// File: rtl/bdac_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdac_back: diagonal average and result register
// Sums the neighbors that lie inside the image, divides by their count with
// a shift and holds the formatted result until the receiver takes it.
// ----------------------------------------------------------------------------
module bdac_back import bdac_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bdac_item_t             head,
	input  wire logic                   empty,
	output      logic                   pop,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic [OUT_TDATA_W-1:0] out_data,
	output      logic [OUT_TUSER_W-1:0] out_user,
	output      logic                   out_last
);

	localparam int SUM_W = PIX_W + 2;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] sum_sh;
	logic [2:0]       n;
	logic [PIX_W-1:0] avg;
	logic             none;

	logic             out_valid_q;
	logic [PIX_W-1:0] cfa_red_q;
	logic [PIX_W-1:0] cfa_green_q;
	logic [PIX_W-1:0] cfa_blue_q;
	logic [PIX_W-1:0] intensity_q;
	channel_t         channel_q;
	logic             no_neighbors_q;
	logic             end_of_row_q;
	logic             end_of_frame_q;

	// sum and count of the neighbors inside the image
	always_comb begin
		sum = (head.use_up_left  ? SUM_W'(head.up_left)  : '0)
		    + (head.use_up_right ? SUM_W'(head.up_right) : '0)
		    + (head.use_left     ? SUM_W'(head.left)     : '0)
		    + (head.use_here     ? SUM_W'(head.here)     : '0);
		n = 3'(head.use_up_left) + 3'(head.use_up_right)
		  + 3'(head.use_left) + 3'(head.use_here);
	end

	// truncating average
	always_comb begin
		case (n)
			3'd4:    sum_sh = sum >> 2;
			3'd2:    sum_sh = sum >> 1;
			default: sum_sh = sum;
		endcase
		none = (n == 3'd0);
		avg  = none ? '0 : sum_sh[PIX_W-1:0];
	end

	// take the next item when the result register is free or drained
	assign pop = !empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (pop) begin
			cfa_red_q      <= (head.channel == CH_RED)   ? avg : '0;
			cfa_green_q    <= (head.channel == CH_GREEN) ? avg : '0;
			cfa_blue_q     <= (head.channel == CH_BLUE)  ? avg : '0;
			intensity_q    <= avg;
			channel_q      <= head.channel;
			no_neighbors_q <= none;
			end_of_row_q   <= head.end_of_row;
			end_of_frame_q <= head.end_of_frame;
		end
	end

	// output packing
	assign out_valid = out_valid_q;
	assign out_data  = {intensity_q, cfa_blue_q, cfa_green_q, cfa_red_q};
	assign out_user  = {end_of_frame_q, no_neighbors_q, channel_q};
	assign out_last  = end_of_row_q;

endmodule
`default_nettype wire

// File: rtl/bayer_diagonal_average_cfa_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_diagonal_average_cfa_unit: RGGB mosaic with diagonal averaging
// RGB pixels enter on the s_axis stream in raster order over a grid of
// (height+2) x (width+2) positions; pixels outside the image are don't care.
// Each position past the first grid row and column gives one mosaic result
// on the m_axis stream: the selected channel averaged over the diagonal
// neighbors that lie inside the image, 0 with no_neighbors set when none do.
// Size registers are written through cfg_we / cfg_index / cfg_data while the
// stream is idle; the grid position carries over and rewraps to the new size.
// Throughput is one pixel per clock unless s_axis_tready is held low, set by
// the line store doing one read and one write per pixel. A result passes the
// stage one register and the queue before it reaches the output register.
// When the receiver stalls, the result register and a four entry queue fill
// and then s_axis_tready drops; nothing is lost.
// After reset all 2*MAX_WIDTH line store entries (2048 at the default size)
// are cleared; s_axis_tready stays low during that pass.
// ----------------------------------------------------------------------------
module bayer_diagonal_average_cfa_unit import bdac_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel request input
	input  wire logic                   s_axis_tvalid,
	output      logic                   s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // red, green, blue
	// mosaic request output
	output      logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output      logic [OUT_TDATA_W-1:0] m_axis_tdata,  // cfa_red, cfa_green, cfa_blue, intensity
	output      logic [OUT_TUSER_W-1:0] m_axis_tuser,  // channel[1:0], no_neighbors, end_of_frame
	output      logic                   m_axis_tlast   // end_of_row
);

	logic       push;
	bdac_item_t push_item;
	logic       queue_full;
	logic       pop;
	bdac_item_t head;
	logic       queue_empty;

	// front end: position tracking, classification, line store
	bdac_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_red     (s_axis_tdata[7:0]),
		.in_green   (s_axis_tdata[15:8]),
		.in_blue    (s_axis_tdata[23:16]),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	// decoupling queue
	bdac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.head      (head),
		.empty     (queue_empty)
	);

	// back end: average and result register
	bdac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (queue_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire
